// ===== rtl/uep0_pkg.sv =====
// shared types and constants for the usb endpoint-0 control sequencer
// no dependencies; imported by every module of the block
`default_nettype none

package uep0_pkg;

  // defaults for the top-level parameters
  localparam int EP0_PACKET_DEFAULT  = 64;
  localparam int BULK_PACKET_DEFAULT = 64;

  localparam int SETUP_LEN      = 8;
  localparam int BULK_FULL_MAX  = 64;
  localparam int BULK_HIGH_MAX  = 512;
  localparam int REQ_DIR_BIT    = 7;

  // configuration register indexes
  localparam logic REG_CLASS_SUPPORTED = 1'b0;

  // actions
  localparam logic [2:0] ACT_NONE       = 3'd0;
  localparam logic [2:0] ACT_CLR_STALL  = 3'd1;
  localparam logic [2:0] ACT_READ_SETUP = 3'd2;
  localparam logic [2:0] ACT_SEND_STALL = 3'd3;
  localparam logic [2:0] ACT_READ_OUT   = 3'd4;
  localparam logic [2:0] ACT_WRITE_IN   = 3'd5;

  // ep0 phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_IN   = 2'd1;
  localparam logic [1:0] PH_OUT  = 2'd2;

  // bus speeds
  localparam logic [1:0] SPD_UNKNOWN = 2'd0;
  localparam logic [1:0] SPD_FULL    = 2'd1;
  localparam logic [1:0] SPD_HIGH    = 2'd2;

  // operations
  localparam logic OP_EVENT = 1'b0;
  localparam logic OP_LOAD  = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [3:0]  bus_events;
    logic        ep0_irq;
    logic        hs_mode;
    logic        ep0_stalled;
    logic        setup_end;
    logic        rx_ready;
    logic [6:0]  rx_len;
    logic [7:0]  request_type;
    logic [15:0] resp_len;
  } uep0_req_t;

  typedef struct packed {
    logic [2:0]  action;
    logic        setup_dispatch;
    logic        ack_setup_end;
    logic [15:0] write_offset;
    logic [6:0]  write_bytes;
    logic        write_last;
    logic [1:0]  phase;
    logic        connected;
    logic [1:0]  speed;
    logic [9:0]  bulk_max_packet;
  } uep0_rsp_t;

  typedef struct packed {
    logic class_supported;
  } uep0_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/uep0_apb_regs.sv =====
// apb configuration register file: holds the class_supported bit
// depends on uep0_pkg
`default_nettype none

module uep0_apb_regs
  import uep0_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output uep0_cfg_t        cfg
);

  logic class_supported;
  logic wr_en;
  logic sel_class;

  assign pready    = 1'b1;
  assign sel_class = (paddr[2] == REG_CLASS_SUPPORTED);
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      class_supported <= 1'b0;
    end else if (wr_en && sel_class) begin
      class_supported <= pwdata[0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (sel_class) begin
      prdata = {31'd0, class_supported};
    end
  end

  assign cfg.class_supported = class_supported;

endmodule

`default_nettype wire

// ===== rtl/uep0_in_stage.sv =====
// input register of the sequencer: takes an item whenever it is empty or
// being drained; depends on uep0_pkg
`default_nettype none

module uep0_in_stage
  import uep0_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_stall,
  input  wire uep0_req_t req,
  input  wire logic      take,
  output logic           item_valid,
  output uep0_req_t      item
);

  logic load;

  assign load      = !item_valid || take;
  assign req_stall = !load;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && req_valid) begin
      item <= req;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/uep0_core.sv =====
// ep0 control state, next-state logic and result register
// depends on uep0_pkg
`default_nettype none

module uep0_core
  import uep0_pkg::*;
#(
  parameter int EP0_PACKET  = EP0_PACKET_DEFAULT,
  parameter int BULK_PACKET = BULK_PACKET_DEFAULT
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire uep0_cfg_t cfg,
  input  wire logic      item_valid,
  input  wire uep0_req_t item,
  output logic           take,
  output logic           rsp_valid,
  input  wire logic      rsp_stall,
  output uep0_rsp_t      rsp
);

  localparam logic [6:0]  PKT_LEN  = 7'(EP0_PACKET);
  localparam logic [15:0] PKT_POS  = 16'(EP0_PACKET);
  localparam logic [6:0]  SETUP_SZ = 7'(SETUP_LEN);
  localparam logic [9:0]  BULK_DEF = 10'(BULK_PACKET);
  localparam logic [9:0]  BULK_FS  = 10'(BULK_FULL_MAX);
  localparam logic [9:0]  BULK_HS  = 10'(BULK_HIGH_MAX);

  logic [1:0]  ep0_phase, ep0_phase_next;
  logic        link_up, link_up_next;
  logic [1:0]  bus_speed, bus_speed_next;
  logic [15:0] tx_position, tx_position_next;
  logic [15:0] tx_total, tx_total_next;

  logic [15:0] remain;
  logic [1:0]  ph_pre;
  uep0_rsp_t   res;

  assign take   = item_valid && (!rsp_valid || !rsp_stall);
  assign remain = (tx_total > tx_position) ? (tx_total - tx_position) : 16'd0;

  always_comb begin
    ep0_phase_next   = ep0_phase;
    link_up_next     = link_up;
    bus_speed_next   = bus_speed;
    tx_position_next = tx_position;
    tx_total_next    = tx_total;
    ph_pre           = ep0_phase;
    res              = '0;

    if (item.operation == OP_LOAD) begin
      tx_total_next = item.resp_len;
      res.action    = ACT_WRITE_IN;
      if (item.resp_len > PKT_POS) begin
        res.write_bytes  = PKT_LEN;
        tx_position_next = PKT_POS;
      end else begin
        res.write_bytes  = item.resp_len[6:0];
        res.write_last   = 1'b1;
        tx_position_next = 16'd0;
      end
    end else if (item.bus_events[0]) begin
      // bus reset ends the item
      link_up_next   = 1'b1;
      ep0_phase_next = PH_IDLE;
    end else begin
      if (item.bus_events[1]) begin
        link_up_next = 1'b1;
      end
      if (item.bus_events[2] || item.bus_events[3]) begin
        link_up_next = 1'b0;
        ph_pre       = PH_IDLE;
      end
      ep0_phase_next = ph_pre;
      if (item.ep0_irq) begin
        if (bus_speed == SPD_UNKNOWN) begin
          bus_speed_next = item.hs_mode ? SPD_HIGH : SPD_FULL;
        end
        if (item.ep0_stalled) begin
          res.action     = ACT_CLR_STALL;
          ep0_phase_next = PH_IDLE;
        end else begin
          if (item.setup_end) begin
            res.ack_setup_end = 1'b1;
            ph_pre            = PH_IDLE;
          end
          // a ready fifo always restarts the transfer: read as a setup packet if SETUP_LEN bytes, else stalled
          if (item.rx_ready) begin
            ph_pre = PH_IDLE;
          end
          ep0_phase_next = ph_pre;
          if (ph_pre == PH_IDLE) begin
            if (item.rx_ready) begin
              if (item.rx_len == SETUP_SZ) begin
                res.action         = ACT_READ_SETUP;
                res.setup_dispatch = cfg.class_supported;
                ep0_phase_next     = item.request_type[REQ_DIR_BIT] ? PH_IN : PH_OUT;
              end else begin
                res.action = ACT_SEND_STALL;
              end
            end
          end else if (ph_pre == PH_IN) begin
            if (tx_position == 16'd0) begin
              ep0_phase_next = PH_IDLE;
            end else begin
              res.action       = ACT_WRITE_IN;
              res.write_offset = tx_position;
              if (remain > PKT_POS) begin
                res.write_bytes  = PKT_LEN;
                tx_position_next = tx_position + PKT_POS;
              end else begin
                res.write_bytes  = remain[6:0];
                res.write_last   = 1'b1;
                tx_position_next = 16'd0;
                ep0_phase_next   = PH_IDLE;
              end
            end
          end
        end
      end
    end

    res.phase     = ep0_phase_next;
    res.connected = link_up_next;
    res.speed     = bus_speed_next;
    case (bus_speed_next)
      SPD_HIGH: res.bulk_max_packet = BULK_HS;
      SPD_FULL: res.bulk_max_packet = BULK_FS;
      default:  res.bulk_max_packet = BULK_DEF;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ep0_phase   <= PH_IDLE;
      link_up     <= 1'b0;
      bus_speed   <= SPD_UNKNOWN;
      tx_position <= 16'd0;
      tx_total    <= 16'd0;
      rsp_valid   <= 1'b0;
    end else begin
      if (take) begin
        ep0_phase   <= ep0_phase_next;
        link_up     <= link_up_next;
        bus_speed   <= bus_speed_next;
        tx_position <= tx_position_next;
        tx_total    <= tx_total_next;
        rsp_valid   <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp <= res;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/usb_ep0_control_sequencer.sv =====
// usb endpoint-0 control sequencer, top level
// an accepted item passes through the input register and then the result register
// one item per cycle unless stalled; ep0 next-state logic sits between the two registers
// rst is synchronous: ep0 idle, link down, speed unknown, transfer position and length zero
// depends on uep0_pkg, uep0_apb_regs, uep0_in_stage and uep0_core
`default_nettype none

module usb_ep0_control_sequencer
  import uep0_pkg::*;
#(
  parameter int EP0_PACKET  = EP0_PACKET_DEFAULT,
  parameter int BULK_PACKET = BULK_PACKET_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire uep0_req_t   req,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output uep0_rsp_t        rsp
);

  uep0_cfg_t cfg;
  uep0_req_t item;
  logic      item_valid;
  logic      take;

  uep0_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  uep0_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  uep0_core #(
    .EP0_PACKET  (EP0_PACKET),
    .BULK_PACKET (BULK_PACKET)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp)
  );

  // packet fields stay clear unless a packet is written
  a_no_pkt_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.action != ACT_WRITE_IN) |->
      (rsp.write_offset == 16'd0) && (rsp.write_bytes == 7'd0) && !rsp.write_last)
    else $error("packet fields set without an IN write");

  a_pkt_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.action == ACT_WRITE_IN) |->
      (rsp.write_bytes <= 7'(EP0_PACKET)) &&
      (rsp.write_last || (rsp.write_bytes == 7'(EP0_PACKET))))
    else $error("IN packet length out of range");

  a_dispatch: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.setup_dispatch |-> (rsp.action == ACT_READ_SETUP) &&
      ((rsp.phase == PH_IN) || (rsp.phase == PH_OUT)))
    else $error("setup dispatched without a setup read");

  a_speed_hold: assert property (@(posedge clk) disable iff (rst)
    take && (u_core.bus_speed != SPD_UNKNOWN) |=> $stable(u_core.bus_speed))
    else $error("bus speed changed after being latched");

endmodule

`default_nettype wire

// ===== bench/tb_usb_ep0_control_sequencer.sv =====
// self-checking testbench for usb_ep0_control_sequencer: directed table, then random transfers
// checks every result against a typed expectation or an in-bench model of the ep0 phase, link, speed and IN progress
// depends on uep0_pkg and the rtl top level only
`timescale 1ns / 1ps

module tb_usb_ep0_control_sequencer;
  import uep0_pkg::*;

  localparam int EP0_PKT     = EP0_PACKET_DEFAULT;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    uep0_req_t req;
    bit        typed;
    uep0_rsp_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        req_valid, req_stall;
  uep0_req_t   req;
  logic        rsp_valid, rsp_stall;
  uep0_rsp_t   rsp;

  // model state
  logic        class_cfg;
  logic [1:0]  ep0_phase_m;
  logic        link_m;
  logic [1:0]  speed_m;
  logic [15:0] in_pos;
  logic [15:0] in_total;

  uep0_rsp_t   expected_rsp[$];
  dir_row_t    dir_rows[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int          tx_left = 0, rx_left = 0;
  bit          tx_quiet = 0, rx_quiet = 0;

  usb_ep0_control_sequencer dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_usb_ep0_control_sequencer failed");
      $finish;
    end
  end

  // stretches of busy and quiet behaviour, one draw per item
  function automatic int draw_wait(inout int left, inout bit quiet);
    if (left == 0) begin
      left  = $urandom_range(5, 40);
      quiet = ($urandom_range(0, 2) == 0);
    end
    left--;
    return quiet ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic uep0_rsp_t next_ep0_result(uep0_req_t r);
    uep0_rsp_t   o;
    logic [15:0] left;
    o = '0;
    if (r.operation == OP_LOAD) begin
      in_total = r.resp_len;
      o.action = ACT_WRITE_IN;
      if (r.resp_len > EP0_PKT) begin
        o.write_bytes = 7'(EP0_PKT);
        in_pos        = 16'(EP0_PKT);
      end else begin
        o.write_bytes = r.resp_len[6:0];
        o.write_last  = 1'b1;
        in_pos        = '0;
      end
    end else if (r.bus_events[0]) begin
      link_m      = 1'b1;
      ep0_phase_m = PH_IDLE;
    end else begin
      // resume, then suspend, then disconnect
      if (r.bus_events[1]) link_m = 1'b1;
      if (r.bus_events[2] || r.bus_events[3]) begin
        link_m      = 1'b0;
        ep0_phase_m = PH_IDLE;
      end
      if (r.ep0_irq) begin
        if (speed_m == SPD_UNKNOWN) speed_m = r.hs_mode ? SPD_HIGH : SPD_FULL;
        if (r.ep0_stalled) begin
          o.action    = ACT_CLR_STALL;
          ep0_phase_m = PH_IDLE;
        end else begin
          if (r.setup_end) begin
            o.ack_setup_end = 1'b1;
            ep0_phase_m     = PH_IDLE;
          end
          if (r.rx_ready) ep0_phase_m = PH_IDLE;
          if (ep0_phase_m == PH_IDLE) begin
            if (r.rx_ready) begin
              if (r.rx_len == SETUP_LEN) begin
                o.action         = ACT_READ_SETUP;
                o.setup_dispatch = class_cfg;
                ep0_phase_m      = r.request_type[REQ_DIR_BIT] ? PH_IN : PH_OUT;
              end else begin
                o.action = ACT_SEND_STALL;
              end
            end
          end else if (ep0_phase_m == PH_IN) begin
            if (in_pos == 0) begin
              ep0_phase_m = PH_IDLE;
            end else begin
              left           = (in_total > in_pos) ? in_total - in_pos : 16'd0;
              o.action       = ACT_WRITE_IN;
              o.write_offset = in_pos;
              if (left > EP0_PKT) begin
                o.write_bytes = 7'(EP0_PKT);
                in_pos        = 16'(in_pos + EP0_PKT);
              end else begin
                o.write_bytes = left[6:0];
                o.write_last  = 1'b1;
                in_pos        = '0;
                ep0_phase_m   = PH_IDLE;
              end
            end
          end
        end
      end
    end
    o.phase     = ep0_phase_m;
    o.connected = link_m;
    o.speed     = speed_m;
    if (speed_m == SPD_HIGH)      o.bulk_max_packet = 10'(BULK_HIGH_MAX);
    else if (speed_m == SPD_FULL) o.bulk_max_packet = 10'(BULK_FULL_MAX);
    else                          o.bulk_max_packet = 10'(BULK_PACKET_DEFAULT);
    return o;
  endfunction

  function automatic uep0_req_t irq_item(logic [3:0] ev, logic irq, logic hs, logic stl,
                                         logic send, logic rdy, logic [6:0] rlen,
                                         logic [7:0] rtype);
    uep0_req_t r;
    r.operation    = OP_EVENT;
    r.bus_events   = ev;
    r.ep0_irq      = irq;
    r.hs_mode      = hs;
    r.ep0_stalled  = stl;
    r.setup_end    = send;
    r.rx_ready     = rdy;
    r.rx_len       = rlen;
    r.request_type = rtype;
    r.resp_len     = 16'($urandom);
    return r;
  endfunction

  function automatic uep0_req_t load_item(logic [15:0] len);
    uep0_req_t r;
    r           = uep0_req_t'(41'({$urandom, $urandom}));
    r.operation = OP_LOAD;
    r.resp_len  = len;
    return r;
  endfunction

  function automatic uep0_req_t noise_item();
    uep0_req_t r;
    r        = uep0_req_t'(41'({$urandom, $urandom}));
    r.rx_len = ($urandom_range(0, 3) == 0) ? 7'(SETUP_LEN) : 7'($urandom_range(0, 64));
    return r;
  endfunction

  function automatic uep0_rsp_t rsp_of(logic [2:0] act, logic [15:0] off, logic [6:0] len,
                                       logic last, logic [1:0] ph, logic conn,
                                       logic [1:0] spd, logic [9:0] bulk);
    uep0_rsp_t o;
    o                 = '0;
    o.action          = act;
    o.write_offset    = off;
    o.write_bytes     = len;
    o.write_last      = last;
    o.phase           = ph;
    o.connected       = conn;
    o.speed           = spd;
    o.bulk_max_packet = bulk;
    return o;
  endfunction

  task automatic add_row(uep0_req_t r, bit typed, uep0_rsp_t want);
    dir_row_t row;
    row.req   = r;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  task automatic send_item(uep0_req_t r, bit typed = 0, uep0_rsp_t want = '0);
    int        gap;
    uep0_rsp_t pred;
    gap = draw_wait(tx_left, tx_quiet);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pred = next_ep0_result(r);
    expected_rsp.push_back(typed ? want : pred);
  endtask

  // hold off until every result is back, then let the pipeline settle
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_class_cfg(logic val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CLASS_SUPPORTED, 2'b00};
    pwdata  <= {31'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    class_cfg = val;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[0] !== val) begin
      $error("class_supported: expected %0d, got %0d", val, prdata[0]);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_setup(logic dir_in);
    logic [7:0] rtype;
    rtype                = 8'($urandom);
    rtype[REQ_DIR_BIT]   = dir_in;
    send_item(irq_item(4'd0, 1'b1, 1'($urandom), 1'b0, ($urandom_range(0, 3) == 0),
                       1'b1, 7'(SETUP_LEN), rtype));
  endtask

  // ep0 interrupt mostly carrying no setup, occasionally with a stall, setup end, ready fifo or bus event
  task automatic send_ep0_irq();
    logic [3:0] ev;
    logic       stl, send, rdy;
    ev   = ($urandom_range(0, 15) == 0) ? 4'($urandom) : 4'd0;
    stl  = ($urandom_range(0, 15) == 0);
    send = ($urandom_range(0, 15) == 0);
    rdy  = ($urandom_range(0, 15) == 0);
    send_item(irq_item(ev, 1'b1, 1'($urandom), stl, send, rdy,
                       7'($urandom_range(0, 64)), 8'($urandom)));
  endtask

  task automatic run_random(int unsigned n);
    int unsigned start;
    int unsigned pick, k, len;
    start = 0;
    while (start < n) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        send_setup(1'b1);
        pick = $urandom_range(0, 19);
        if (pick == 0)      len = ($urandom_range(0, 1) == 0) ? 65535 : $urandom_range(0, 65535);
        else if (pick <= 3) len = $urandom_range(0, 2000);
        else                len = $urandom_range(0, 400);
        send_item(load_item(16'(len)));
        k = (len <= 2048) ? len / EP0_PKT + $urandom_range(0, 2) : $urandom_range(1, 12);
        repeat (k) send_ep0_irq();
        start += 2 + k;
      end else if (pick <= 7) begin
        send_setup(1'b0);
        k = $urandom_range(0, 4);
        repeat (k) send_ep0_irq();
        start += 1 + k;
      end else if (pick == 8) begin
        k = $urandom_range(1, 3);
        repeat (k) send_item(noise_item());
        start += k;
      end else begin
        send_item(irq_item(4'($urandom_range(1, 15)), 1'($urandom), 1'($urandom),
                           1'($urandom), 1'($urandom), 1'($urandom),
                           7'($urandom_range(0, 64)), 8'($urandom)));
        start += 1;
      end
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_result(uep0_rsp_t got);
    uep0_rsp_t want;
    if (expected_rsp.size() == 0) begin
      $error("unexpected result item: action %0d", got.action);
      mismatches++;
    end else begin
      want = expected_rsp.pop_front();
      check_field("action", want.action, got.action);
      check_field("setup_dispatch", want.setup_dispatch, got.setup_dispatch);
      check_field("ack_setup_end", want.ack_setup_end, got.ack_setup_end);
      check_field("write_offset", want.write_offset, got.write_offset);
      check_field("write_bytes", want.write_bytes, got.write_bytes);
      check_field("write_last", want.write_last, got.write_last);
      check_field("phase", want.phase, got.phase);
      check_field("connected", want.connected, got.connected);
      check_field("speed", want.speed, got.speed);
      check_field("bulk_max_packet", want.bulk_max_packet, got.bulk_max_packet);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && !rsp_stall) compare_result(rsp);
  end

  // result side back-pressure
  initial begin
    int n;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      n = draw_wait(rx_left, rx_quiet);
      if (n > 0) begin
        rsp_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      @(posedge clk);
      while (rsp_valid !== 1'b1) @(posedge clk);
    end
  end

  initial begin
    uep0_rsp_t none_rsp;
    none_rsp    = '0;
    rst         <= 1'b1;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    req_valid   <= 1'b0;
    req         <= '0;
    rsp_stall   <= 1'b0;
    class_cfg   = 1'b0;
    ep0_phase_m = PH_IDLE;
    link_m      = 1'b0;
    speed_m     = SPD_UNKNOWN;
    in_pos      = '0;
    in_total    = '0;

    // directed rows: typed expectations where the answer is plain, the in-bench model for the rest
    add_row(irq_item(4'd0, 0, 0, 0, 0, 0, 7'd0, 8'h00), 1,
            rsp_of(ACT_NONE, 0, 0, 0, PH_IDLE, 0, SPD_UNKNOWN, 10'(BULK_PACKET_DEFAULT)));
    add_row(load_item(16'd0), 1,
            rsp_of(ACT_WRITE_IN, 0, 0, 1, PH_IDLE, 0, SPD_UNKNOWN, 10'(BULK_PACKET_DEFAULT)));
    // bus reset swallows the ep0 interrupt, so speed stays unknown
    add_row(irq_item(4'h1, 1, 1, 1, 1, 1, 7'd8, 8'hFF), 1,
            rsp_of(ACT_NONE, 0, 0, 0, PH_IDLE, 1, SPD_UNKNOWN, 10'(BULK_PACKET_DEFAULT)));
    // stall wins over setup end and a ready fifo; first irq latches high speed
    add_row(irq_item(4'h0, 1, 1, 1, 1, 1, 7'd8, 8'hFF), 1,
            rsp_of(ACT_CLR_STALL, 0, 0, 0, PH_IDLE, 1, SPD_HIGH, 10'(BULK_HIGH_MAX)));
    add_row(irq_item(4'h0, 1, 0, 0, 0, 1, 7'd0, 8'hFF), 1,
            rsp_of(ACT_SEND_STALL, 0, 0, 0, PH_IDLE, 1, SPD_HIGH, 10'(BULK_HIGH_MAX)));
    add_row(irq_item(4'h0, 1, 0, 0, 0, 1, 7'd64, 8'h00), 1,
            rsp_of(ACT_SEND_STALL, 0, 0, 0, PH_IDLE, 1, SPD_HIGH, 10'(BULK_HIGH_MAX)));
    add_row(irq_item(4'h0, 1, 0, 0, 1, 1, 7'd8, 8'hFF), 0, none_rsp);
    // IN phase with nothing loaded drops back to idle
    add_row(irq_item(4'h0, 1, 1, 0, 0, 0, 7'd127, 8'h00), 0, none_rsp);
    add_row(irq_item(4'h0, 1, 0, 0, 0, 1, 7'd8, 8'h80), 0, none_rsp);
    add_row(load_item(16'hFFFF), 1,
            rsp_of(ACT_WRITE_IN, 0, 7'(EP0_PKT), 0, PH_IN, 1, SPD_HIGH, 10'(BULK_HIGH_MAX)));
    add_row(irq_item(4'h0, 1, 0, 0, 0, 0, 7'd0, 8'h00), 0, none_rsp);
    add_row(irq_item(4'h0, 1, 0, 0, 1, 0, 7'd0, 8'h00), 0, none_rsp);
    add_row(irq_item(4'h0, 1, 0, 0, 0, 1, 7'd8, 8'hC1), 0, none_rsp);
    add_row(load_item(16'd130), 0, none_rsp);
    add_row(irq_item(4'h0, 1, 1, 0, 0, 0, 7'd5, 8'h3C), 0, none_rsp);
    add_row(irq_item(4'h0, 1, 0, 0, 0, 0, 7'd0, 8'h00), 0, none_rsp);
    add_row(irq_item(4'h0, 1, 0, 0, 0, 0, 7'd0, 8'h00), 0, none_rsp);
    add_row(irq_item(4'h0, 1, 0, 0, 0, 1, 7'd8, 8'h7F), 0, none_rsp);
    add_row(irq_item(4'h0, 1, 0, 0, 0, 0, 7'd8, 8'hFF), 0, none_rsp);
    add_row(irq_item(4'h4, 0, 0, 0, 0, 0, 7'd0, 8'h00), 0, none_rsp);
    add_row(irq_item(4'h2, 0, 0, 0, 0, 0, 7'd0, 8'h00), 0, none_rsp);
    // resume, suspend and disconnect together, then a setup in the same item
    add_row(irq_item(4'hE, 1, 0, 0, 0, 1, 7'd8, 8'h80), 0, none_rsp);
    add_row(irq_item(4'h8, 1, 0, 0, 0, 0, 7'd0, 8'h00), 0, none_rsp);
    add_row(irq_item(4'hF, 1, 1, 1, 1, 1, 7'd8, 8'h80), 0, none_rsp);
    add_row(load_item(16'd64), 0, none_rsp);
    add_row(load_item(16'd65), 0, none_rsp);
    add_row(irq_item(4'h0, 1, 0, 0, 0, 0, 7'd0, 8'h00), 0, none_rsp);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_class_cfg(1'b1);
    foreach (dir_rows[i]) send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
    wait_drained();

    write_class_cfg(1'b0);
    run_random(170);
    wait_drained();

    write_class_cfg(1'b1);
    run_random(170);
    wait_drained();

    write_class_cfg(1'b0);
    run_random(160);
    wait_drained();
    repeat (8) @(posedge clk);

    if (mismatches == 0 && expected_rsp.size() == 0) begin
      $display("tb_usb_ep0_control_sequencer passed");
    end else begin
      $display("tb_usb_ep0_control_sequencer failed");
    end
    $finish;
  end

endmodule
